>>> design/bal_pkg.sv
// Shared definitions for the byte ALU with decimal-mode flags.
// Action codes, status bit positions and BCD constants; no dependencies.
package bal_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ActW  = 4;

  // Status bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  // Decimal correction constants
  localparam logic [9:0] BcdLoAdj  = 10'h006;
  localparam logic [9:0] BcdHiAdj  = 10'h060;
  localparam logic [9:0] BcdMax    = 10'h099;
  localparam logic [4:0] BcdDigMax = 5'd9;

  typedef enum logic [ActW-1:0] {
    ACT_ADC  = 4'd0,
    ACT_SBC  = 4'd1,
    ACT_ASL  = 4'd2,
    ACT_LSR  = 4'd3,
    ACT_ROL  = 4'd4,
    ACT_ROR  = 4'd5,
    ACT_AND  = 4'd6,
    ACT_ORA  = 4'd7,
    ACT_EOR  = 4'd8,
    ACT_CMP  = 4'd9,
    ACT_BIT  = 4'd10,
    ACT_INC  = 4'd11,
    ACT_DEC  = 4'd12,
    ACT_LOAD = 4'd13
  } action_t;

  // One registered ALU item
  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [ByteW-1:0] reg_in;
    logic [ByteW-1:0] operand;
    logic [ByteW-1:0] status_in;
  } alu_item_t;

endpackage

>>> design/bal_alu.sv
// Combinational byte ALU: binary and decimal ADC/SBC, shifts, logic ops,
// compare, BIT, inc/dec and load. Depends on bal_pkg.
module bal_alu
  import bal_pkg::*;
(
  input  alu_item_t        item,
  output logic [ByteW-1:0] result,
  output logic [ByteW-1:0] status_out
);

  logic [ByteW-1:0] a;
  logic [ByteW-1:0] v;
  logic [ByteW-1:0] p;
  logic             cin;
  logic             borrow;

  logic [8:0]       add_sum;
  logic [ByteW-1:0] add_bin;
  logic             add_v;
  logic [4:0]       add_lo;
  logic [9:0]       dec_adj;
  logic             dec_c;
  logic [9:0]       dec_fin;

  logic [8:0]       sub_diff;
  logic [ByteW-1:0] sub_bin;
  logic             sub_v;
  logic signed [5:0] sub_lo;
  logic signed [5:0] sub_hi;
  logic signed [5:0] sub_lo_fix;
  logic signed [5:0] sub_hi_dec;
  logic signed [5:0] sub_hi_fix;
  logic [ByteW-1:0] sub_dres;

  logic [ByteW-1:0] res;
  logic [ByteW-1:0] st;

  assign a      = item.reg_in;
  assign v      = item.operand;
  assign p      = item.status_in;
  assign cin    = p[FlagC];
  assign borrow = ~p[FlagC];

  // Addition path
  assign add_sum = {1'b0, a} + {1'b0, v} + {8'd0, cin};
  assign add_bin = add_sum[7:0];
  assign add_v   = (a[7] ^ add_bin[7]) & (v[7] ^ add_bin[7]);
  assign add_lo  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
  assign dec_adj = {1'b0, add_sum} + ((add_lo > BcdDigMax) ? BcdLoAdj : 10'd0);
  assign dec_c   = dec_adj > BcdMax;
  assign dec_fin = dec_c ? (dec_adj + BcdHiAdj) : dec_adj;

  // Subtraction path
  assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, borrow};
  assign sub_bin  = sub_diff[7:0];
  assign sub_v    = (a[7] ^ v[7]) & (a[7] ^ sub_bin[7]);
  assign sub_lo   = $signed({2'b00, a[3:0]}) - $signed({2'b00, v[3:0]})
                    - $signed({5'd0, borrow});
  assign sub_hi   = $signed({2'b00, a[7:4]}) - $signed({2'b00, v[7:4]});
  assign sub_lo_fix = sub_lo[5] ? (sub_lo - 6'sd6) : sub_lo;
  assign sub_hi_dec = sub_lo[5] ? (sub_hi - 6'sd1) : sub_hi;
  assign sub_hi_fix = sub_hi_dec[5] ? (sub_hi_dec - 6'sd6) : sub_hi_dec;
  assign sub_dres   = {sub_hi_fix[3:0], sub_lo_fix[3:0]};

  always_comb begin
    res = a;
    st  = p;
    case (item.action)
      ACT_ADC: begin
        res       = p[FlagD] ? dec_fin[7:0] : add_bin;
        st[FlagV] = add_v;
        st[FlagC] = p[FlagD] ? dec_c : add_sum[8];
      end
      ACT_SBC: begin
        res       = p[FlagD] ? sub_dres : sub_bin;
        st[FlagV] = sub_v;
        st[FlagC] = ~sub_diff[8];
      end
      ACT_ASL: begin
        res       = {v[6:0], 1'b0};
        st[FlagC] = v[7];
      end
      ACT_LSR: begin
        res       = {1'b0, v[7:1]};
        st[FlagC] = v[0];
      end
      ACT_ROL: begin
        res       = {v[6:0], cin};
        st[FlagC] = v[7];
      end
      ACT_ROR: begin
        res       = {cin, v[7:1]};
        st[FlagC] = v[0];
      end
      ACT_AND:  res = a & v;
      ACT_ORA:  res = a | v;
      ACT_EOR:  res = a ^ v;
      ACT_CMP: begin
        st[FlagC] = (a >= v);
      end
      ACT_BIT: begin
        st[FlagV] = v[6];
      end
      ACT_INC:  res = v + 8'd1;
      ACT_DEC:  res = v - 8'd1;
      ACT_LOAD: res = v;
      default: begin
        res = a;
        st  = p;
      end
    endcase

    // Z and N: compare and BIT take them from their own values
    case (item.action)
      ACT_ADC, ACT_SBC, ACT_ASL, ACT_LSR, ACT_ROL, ACT_ROR, ACT_AND, ACT_ORA,
      ACT_EOR, ACT_INC, ACT_DEC, ACT_LOAD: begin
        st[FlagZ] = (res == 8'd0);
        st[FlagN] = res[7];
      end
      ACT_CMP: begin
        st[FlagZ] = (a == v);
        st[FlagN] = ((a - v) >> 7) != 8'd0;
      end
      ACT_BIT: begin
        st[FlagZ] = ((a & v) == 8'd0);
        st[FlagN] = v[7];
      end
      default: begin
        st[FlagZ] = p[FlagZ];
        st[FlagN] = p[FlagN];
      end
    endcase
  end

  assign result     = res;
  assign status_out = st;

endmodule

>>> design/byte_alu_with_bcd_flags.sv
// Top level of the byte ALU: input register, ALU core, result register.
// Depends on bal_pkg and bal_alu.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+-----------------------------------------
//   in      | in_valid  | in_ready  | action, reg_in, operand, status_in
//   out     | out_valid | out_ready | result, status_out
//
// An accepted item is captured in the input register, passes through the
// combinational ALU and is loaded into the result register once that register
// is free or draining; one item per cycle is sustained while out is not stalled.
// rst (synchronous) empties both stages; payload registers are not reset.
// A stall on out holds the result register; the input stage still takes an
// item while it is empty, so an item can be accepted while a result waits.
module byte_alu_with_bcd_flags
  import bal_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ActW-1:0]  action,
  input  logic [ByteW-1:0] reg_in,
  input  logic [ByteW-1:0] operand,
  input  logic [ByteW-1:0] status_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] result,
  output logic [ByteW-1:0] status_out
);

  alu_item_t        s1_item;
  logic             s1_valid;
  logic             s1_advance;
  logic [ByteW-1:0] alu_result;
  logic [ByteW-1:0] alu_status;
  logic             in_take;

  assign s1_advance = ~out_valid | out_ready;
  assign in_ready   = ~s1_valid | s1_advance;
  assign in_take    = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= '{action: action, reg_in: reg_in, operand: operand,
                   status_in: status_in};
    end
  end

  bal_alu u_alu (
    .item       (s1_item),
    .result     (alu_result),
    .status_out (alu_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  // Load the result register only when it is free or being drained
  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      result     <= alu_result;
      status_out <= alu_status;
    end
  end

  a_take_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("accepted item did not reach the input stage");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_item))
    else $error("input stage item dropped or changed while stalled");

  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance |=> out_valid)
    else $error("advanced item did not reach the result register");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("empty input stage refused an item");

endmodule
